>>> src/co2dta_pkg.sv
// Shared types and constants for the CO2 delayed threshold alarm block.
// Used by the limit lane, the top level and the testbench; depends on nothing.
package co2dta_pkg;

   localparam int OUT_LIMITS    = 4;
   localparam int CSR_IDX_BITS  = 3;
   localparam int DELAY_MS_BITS = 26;

   localparam logic [15:0] LEVEL_CLAMP  = 16'd6000;
   localparam logic [14:0] CURRENT_BASE = 15'd4000;
   localparam logic [15:0] DIV3_RECIP   = 16'd43691;
   localparam int          DIV3_SHIFT   = 17;
   localparam logic [9:0]  MS_PER_S     = 10'd1000;

   localparam logic [15:0]              THRESHOLD_RESET = 16'hFFFF;
   localparam logic [DELAY_MS_BITS-1:0] PERIOD_RESET_MS = 26'd60000;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_THRESHOLD_1 = 3'd0,
      REG_THRESHOLD_2 = 3'd1,
      REG_THRESHOLD_3 = 3'd2,
      REG_THRESHOLD_4 = 3'd3,
      REG_DELAY_TABLE = 3'd4,
      REG_ID_SET_MASK = 3'd5,
      REG_CONT_PERIOD = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_START    = 2'd1,
      EV_CONTINUE = 2'd2,
      EV_END      = 2'd3
   } event_type;

   typedef struct packed {
      logic [15:0]              threshold;
      logic [DELAY_MS_BITS-1:0] delay_ms;
   } limit_cfg_type;

endpackage

>>> src/co2dta_limit.sv
// One alarm limit: threshold compare, qualifying delay and start/continue/end events.
// Depends on co2dta_pkg.
module co2dta_limit #(
   parameter int TIME_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    adv,
   input  logic                                    eval,
   input  co2dta_pkg::limit_cfg_type               cfg,
   input  logic [15:0]                             level,
   input  logic [co2dta_pkg::DELAY_MS_BITS-1:0]    period_ms,
   input  logic [TIME_BITS-1:0]                    now,
   output co2dta_pkg::event_type                   lim_event,
   output logic                                    crossed
);

   localparam int CMP_BITS = (TIME_BITS > co2dta_pkg::DELAY_MS_BITS) ?
                             TIME_BITS : co2dta_pkg::DELAY_MS_BITS;

   logic                 crossed_ff, crossed_in;
   logic                 running_ff, running_in;
   logic [TIME_BITS-1:0] dly_start_ff, dly_start_in;
   logic [TIME_BITS-1:0] last_cont_ff, last_cont_in;

   logic                 above;
   logic                 has_delay;
   logic                 delay_wait;
   logic                 cont_due;
   logic [TIME_BITS-1:0] elapsed_dly;
   logic [TIME_BITS-1:0] elapsed_cont;

   assign above        = level > cfg.threshold;
   assign has_delay    = cfg.delay_ms != '0;
   assign elapsed_dly  = now - dly_start_ff;
   assign elapsed_cont = now - last_cont_ff;
   assign delay_wait   = CMP_BITS'(elapsed_dly) < CMP_BITS'(cfg.delay_ms);
   assign cont_due     = CMP_BITS'(elapsed_cont) > CMP_BITS'(period_ms);

   always_comb begin
      crossed_in   = crossed_ff;
      running_in   = running_ff;
      dly_start_in = dly_start_ff;
      last_cont_in = last_cont_ff;
      lim_event    = co2dta_pkg::EV_NONE;
      if (above) begin
         if (has_delay && !running_ff) begin
            running_in   = 1'b1;
            dly_start_in = now;
         end else if (!(has_delay && delay_wait)) begin
            if (!crossed_ff) begin
               lim_event    = co2dta_pkg::EV_START;
               last_cont_in = now;
            end else if (cont_due) begin
               lim_event    = co2dta_pkg::EV_CONTINUE;
               last_cont_in = now;
            end
            crossed_in = 1'b1;
         end
      end else begin
         running_in = 1'b0;
         if (crossed_ff) begin
            lim_event  = co2dta_pkg::EV_END;
            crossed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crossed_ff <= 1'b0;
         running_ff <= 1'b0;
      end else if (adv && eval) begin
         crossed_ff <= crossed_in;
         running_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && eval) begin
         dly_start_ff <= dly_start_in;
         last_cont_ff <= last_cont_in;
      end
   end

   assign crossed = crossed_ff;

endmodule

>>> src/co2_delayed_threshold_alarms.sv
// Top level of the CO2 delayed threshold alarm block: handshakes, settings,
// sensor fault handling and the 4-20 mA output. Depends on co2dta_pkg and co2dta_limit.
//
// One poll tick is taken per clock cycle unless req_stall is high. A transfer on the
// request channel lands in an input register; once the response register can take it,
// the level, fault, buzzer and, with a known level, every limit lane are updated in a
// single pass and the result is held in the response register. The input register keeps
// taking ticks while a result waits; requests stall only when both registers are full.
// Settings are written through the csr port, which is always ready; the user must write
// them only while no tick is in flight, as the block itself does not enforce this.
module co2_delayed_threshold_alarms #(
   parameter int LIMIT_COUNT = 4,
   parameter int TIME_BITS   = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_has_sample,
   input  logic                                  req_co2_present,
   input  logic [15:0]                           req_co2_ppm,
   input  logic [31:0]                           req_time_ms,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_event_1,
   output logic [1:0]                            rsp_event_2,
   output logic [1:0]                            rsp_event_3,
   output logic [1:0]                            rsp_event_4,
   output logic [3:0]                            rsp_alarm_mask,
   output logic                                  rsp_fault_led,
   output logic                                  rsp_buzzer_on,
   output logic [14:0]                           rsp_loop_current_ua,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [co2dta_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [63:0]                           csr_data
);

   localparam int NUM_LANES = (LIMIT_COUNT < co2dta_pkg::OUT_LIMITS) ?
                              LIMIT_COUNT : co2dta_pkg::OUT_LIMITS;
   localparam int DMS       = co2dta_pkg::DELAY_MS_BITS;

   logic [15:0]    thr_ff      [co2dta_pkg::OUT_LIMITS];
   logic [DMS-1:0] delay_ms_ff [co2dta_pkg::OUT_LIMITS];
   logic [3:0]     id_mask_ff;
   logic [DMS-1:0] period_ms_ff;

   logic        in_vld_ff, in_vld_in;
   logic        in_has_ff;
   logic        in_present_ff;
   logic [15:0] in_ppm_ff;
   logic [31:0] in_time_ff;

   logic        rsp_vld_ff, rsp_vld_in;
   logic        accept;
   logic        adv;

   logic        known_ff, known_in;
   logic [15:0] level_ff, level_in;
   logic        fault_ff, fault_in;
   logic        buzzer_ff, buzzer_in;
   logic        good_sample;

   logic [12:0] clamped;
   logic [15:0] scaled;
   logic [31:0] recip_prod;
   logic [13:0] quotient;
   logic [14:0] current_ff, current_in;

   logic [TIME_BITS-1:0]  now;
   co2dta_pkg::event_type ev_w  [co2dta_pkg::OUT_LIMITS];
   logic [1:0]            ev_ff [co2dta_pkg::OUT_LIMITS];
   logic [3:0]            crossed_w;

   // Settings.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < co2dta_pkg::OUT_LIMITS; k++) begin
            thr_ff[k]      <= co2dta_pkg::THRESHOLD_RESET;
            delay_ms_ff[k] <= '0;
         end
         id_mask_ff   <= '0;
         period_ms_ff <= co2dta_pkg::PERIOD_RESET_MS;
      end else if (csr_valid && csr_ready) begin
         case (co2dta_pkg::csr_index_type'(csr_index))
            co2dta_pkg::REG_THRESHOLD_1, co2dta_pkg::REG_THRESHOLD_2,
            co2dta_pkg::REG_THRESHOLD_3, co2dta_pkg::REG_THRESHOLD_4: begin
               thr_ff[csr_index[1:0]] <= csr_data[15:0];
            end
            co2dta_pkg::REG_DELAY_TABLE: begin
               for (int k = 0; k < co2dta_pkg::OUT_LIMITS; k++) begin
                  delay_ms_ff[k] <= DMS'(csr_data[16*k +: 16]) *
                                    DMS'(co2dta_pkg::MS_PER_S);
               end
            end
            co2dta_pkg::REG_ID_SET_MASK: begin
               id_mask_ff <= csr_data[3:0];
            end
            co2dta_pkg::REG_CONT_PERIOD: begin
               period_ms_ff <= DMS'(csr_data[15:0]) * DMS'(co2dta_pkg::MS_PER_S);
            end
            default: begin
            end
         endcase
      end
   end

   // Handshake and pipeline control.
   assign req_stall  = in_vld_ff && rsp_vld_ff && rsp_stall;
   assign accept     = req_valid && !req_stall;
   assign adv        = in_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign in_vld_in  = accept ? 1'b1 : (adv ? 1'b0 : in_vld_ff);
   assign rsp_vld_in = adv ? 1'b1 : (rsp_stall ? rsp_vld_ff : 1'b0);

   // Sample handling.
   assign good_sample = in_present_ff && (in_ppm_ff != '0);

   always_comb begin
      known_in  = known_ff;
      level_in  = level_ff;
      fault_in  = fault_ff;
      buzzer_in = buzzer_ff;
      if (in_has_ff) begin
         if (good_sample) begin
            known_in  = 1'b1;
            level_in  = in_ppm_ff;
            fault_in  = 1'b0;
            buzzer_in = 1'b0;
         end else begin
            known_in  = 1'b0;
            fault_in  = 1'b1;
            buzzer_in = !buzzer_ff;
         end
      end
   end

   // Loop current: 4000 + (8 * min(level, 6000) + 1) / 3, via a reciprocal multiply.
   assign clamped    = (level_in > co2dta_pkg::LEVEL_CLAMP) ?
                       co2dta_pkg::LEVEL_CLAMP[12:0] : level_in[12:0];
   assign scaled     = {clamped, 3'b000} + 16'd1;
   assign recip_prod = 32'(scaled) * 32'(co2dta_pkg::DIV3_RECIP);
   assign quotient   = recip_prod[co2dta_pkg::DIV3_SHIFT +: 14];
   assign current_in = known_in ? (co2dta_pkg::CURRENT_BASE + 15'(quotient)) : '0;

   assign now = TIME_BITS'(in_time_ff);

   // Limit lanes.
   for (genvar gk = 0; gk < co2dta_pkg::OUT_LIMITS; gk++) begin : g_lane
      if (gk < NUM_LANES) begin : g_on
         co2dta_pkg::limit_cfg_type lane_cfg;

         assign lane_cfg.threshold = thr_ff[gk];
         assign lane_cfg.delay_ms  = delay_ms_ff[gk];

         co2dta_limit #(
            .TIME_BITS (TIME_BITS)
         ) u_limit (
            .clock     (clock),
            .reset     (reset),
            .adv       (adv),
            .eval      (known_in),
            .cfg       (lane_cfg),
            .level     (level_in),
            .period_ms (period_ms_ff),
            .now       (now),
            .lim_event (ev_w[gk]),
            .crossed   (crossed_w[gk])
         );
      end else begin : g_off
         assign ev_w[gk]      = co2dta_pkg::EV_NONE;
         assign crossed_w[gk] = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         known_ff   <= 1'b0;
         fault_ff   <= 1'b0;
         buzzer_ff  <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (adv) begin
            known_ff  <= known_in;
            fault_ff  <= fault_in;
            buzzer_ff <= buzzer_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_has_ff     <= req_has_sample;
         in_present_ff <= req_co2_present;
         in_ppm_ff     <= req_co2_ppm;
         in_time_ff    <= req_time_ms;
      end
      if (adv) begin
         level_ff   <= level_in;
         current_ff <= current_in;
         for (int k = 0; k < co2dta_pkg::OUT_LIMITS; k++) begin
            ev_ff[k] <= (known_in && id_mask_ff[k]) ? ev_w[k] : co2dta_pkg::EV_NONE;
         end
      end
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_event_1         = ev_ff[0];
   assign rsp_event_2         = ev_ff[1];
   assign rsp_event_3         = ev_ff[2];
   assign rsp_event_4         = ev_ff[3];
   assign rsp_alarm_mask      = crossed_w;
   assign rsp_fault_led       = fault_ff;
   assign rsp_buzzer_on       = buzzer_ff;
   assign rsp_loop_current_ua = current_ff;

endmodule

>>> src/co2dta_checker.sv
// Port-level checker for the CO2 delayed threshold alarm block, with its bind.
// Depends on the top level's port list.
module co2dta_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [1:0]                            rsp_event_1,
   input logic [1:0]                            rsp_event_2,
   input logic [1:0]                            rsp_event_3,
   input logic [1:0]                            rsp_event_4,
   input logic [3:0]                            rsp_alarm_mask,
   input logic                                  rsp_fault_led,
   input logic                                  rsp_buzzer_on,
   input logic [14:0]                           rsp_loop_current_ua
);

   // A stalled result stays offered, with its loop current, alarm mask and events 1 and 4 unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_loop_current_ua) &&
      $stable(rsp_alarm_mask) && $stable(rsp_event_1) && $stable(rsp_event_4))
      else $error("stalled result changed");

   // Requests are held back only while a result is waiting.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a waiting result");

   // A sensor fault leaves no known level, so the loop output is off.
   a_fault_current: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault_led |-> rsp_loop_current_ua == 15'd0)
      else $error("loop current driven during a fault");

   // Without a known level no events are reported.
   a_no_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_loop_current_ua == 15'd0 |->
      rsp_event_1 == 2'd0 && rsp_event_2 == 2'd0 &&
      rsp_event_3 == 2'd0 && rsp_event_4 == 2'd0)
      else $error("event reported without a known level");

   // The buzzer only sounds while the fault indicator is lit.
   a_buzzer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fault_led |-> !rsp_buzzer_on)
      else $error("buzzer on without a fault");

endmodule

bind co2_delayed_threshold_alarms co2dta_checker u_checker (.*);

>>> dv/tb_top.sv
// Self-checking testbench for co2_delayed_threshold_alarms: a directed table, then random
// ticks under several settings, each transfer checked against the table or a local predictor.
// Depends on co2dta_pkg and the top level of the block.
`timescale 1ns / 100ps

module tb_top;

   localparam int          PHASES          = 8;
   localparam int          ITEMS_PER_PHASE = 125;
   localparam int          TIMEOUT_NS      = 5_000_000;
   localparam int          MAX_PRINTED     = 40;
   localparam logic [2:0]  REG_UNUSED      = 3'd7;
   localparam int unsigned CLAMP_PPM       = 6000;
   localparam int unsigned BASE_UA         = 4000;

   typedef enum bit {ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      bit           has_sample;
      bit           co2_present;
      logic [15:0]  ppm;
      logic [31:0]  time_ms;
      logic [2:0]   idx;
      logic [63:0]  data;
      bit           literal;
      bit           fault;
      bit           buzzer;
      logic [14:0]  current;
   } stim_row_type;

   typedef struct packed {
      logic [3:0][1:0] ev;
      logic [3:0]      alarm_mask;
      logic            fault_led;
      logic            buzzer_on;
      logic [14:0]     current_ua;
   } alarm_result_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_has_sample  = 1'b0;
   logic        req_co2_present = 1'b0;
   logic [15:0] req_co2_ppm     = '0;
   logic [31:0] req_time_ms     = '0;
   logic        rsp_stall       = 1'b0;
   logic        csr_valid       = 1'b0;
   logic [2:0]  csr_index       = '0;
   logic [63:0] csr_data        = '0;
   logic        req_stall;
   logic        rsp_valid;
   logic [1:0]  rsp_event_1, rsp_event_2, rsp_event_3, rsp_event_4;
   logic [3:0]  rsp_alarm_mask;
   logic        rsp_fault_led;
   logic        rsp_buzzer_on;
   logic [14:0] rsp_loop_current_ua;
   logic        csr_ready;

   co2_delayed_threshold_alarms i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_has_sample      (req_has_sample),
      .req_co2_present     (req_co2_present),
      .req_co2_ppm         (req_co2_ppm),
      .req_time_ms         (req_time_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_event_1         (rsp_event_1),
      .rsp_event_2         (rsp_event_2),
      .rsp_event_3         (rsp_event_3),
      .rsp_event_4         (rsp_event_4),
      .rsp_alarm_mask      (rsp_alarm_mask),
      .rsp_fault_led       (rsp_fault_led),
      .rsp_buzzer_on       (rsp_buzzer_on),
      .rsp_loop_current_ua (rsp_loop_current_ua),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #6 clock = ~clock;

   // Settings and state of the predicted alarm block.
   logic [15:0] thr_cfg [4] = '{default: 16'hFFFF};
   logic [63:0] delay_cfg   = '0;
   logic [3:0]  id_mask_cfg = '0;
   logic [15:0] period_cfg  = 16'd60;
   logic [15:0] level_ppm   = '0;
   bit          level_known = 1'b0;
   bit          crossed_q [4]   = '{default: 1'b0};
   bit          timer_on [4]    = '{default: 1'b0};
   logic [31:0] timer_start [4] = '{default: '0};
   logic [31:0] last_report [4] = '{default: '0};
   bit          fault_q  = 1'b0;
   bit          buzzer_q = 1'b0;

   alarm_result_type pending_results [$];
   int error_count     = 0;
   int ticks_sent      = 0;
   int results_checked = 0;
   int starts_seen     = 0;
   int continues_seen  = 0;
   int ends_seen       = 0;
   int faults_seen     = 0;
   bit no_idle         = 1'b1;
   int stall_left      = 0;

   stim_row_type directed_rows [0:34] = '{
      '{ROW_TICK, 1'b0, 1'b0, 0, 0, 0, 0, 1, 0, 0, 0},
      '{ROW_TICK, 1, 1, 100,   1000,  0, 0, 1, 0, 0, 4267},
      '{ROW_TICK, 1, 1, 6000,  2000,  0, 0, 1, 0, 0, 20000},
      '{ROW_TICK, 1, 1, 65535, 3000,  0, 0, 1, 0, 0, 20000},
      '{ROW_TICK, 0, 1, 777,   4000,  0, 0, 1, 0, 0, 20000},
      '{ROW_TICK, 1, 1, 0,     5000,  0, 0, 1, 1, 1, 0},
      '{ROW_TICK, 1, 0, 500,   6000,  0, 0, 1, 1, 0, 0},
      '{ROW_TICK, 0, 0, 0,     7000,  0, 0, 1, 1, 0, 0},
      '{ROW_TICK, 1, 0, 0,     8000,  0, 0, 1, 1, 1, 0},
      '{ROW_TICK, 1, 1, 1,     9000,  0, 0, 1, 0, 0, 4003},
      '{ROW_TICK, 1, 1, 6001,  9500,  0, 0, 1, 0, 0, 20000},
      '{ROW_CSR, 0, 0, 0, 0, co2dta_pkg::REG_THRESHOLD_1, 64'hFFFF_FFFF_FFFF_03E8, 0, 0, 0, 0},
      '{ROW_CSR, 0, 0, 0, 0, co2dta_pkg::REG_THRESHOLD_2, 64'h0,                   0, 0, 0, 0},
      '{ROW_CSR, 0, 0, 0, 0, co2dta_pkg::REG_THRESHOLD_3, 64'd2000,                0, 0, 0, 0},
      '{ROW_CSR, 0, 0, 0, 0, co2dta_pkg::REG_THRESHOLD_4, 64'd1500,                0, 0, 0, 0},
      '{ROW_CSR, 0, 0, 0, 0, co2dta_pkg::REG_DELAY_TABLE, 64'h0000_0002_0000_0000, 0, 0, 0, 0},
      '{ROW_CSR, 0, 0, 0, 0, co2dta_pkg::REG_ID_SET_MASK, 64'hFFFF_FFFF_FFFF_FFF7, 0, 0, 0, 0},
      '{ROW_CSR, 0, 0, 0, 0, co2dta_pkg::REG_CONT_PERIOD, 64'd1,                   0, 0, 0, 0},
      '{ROW_CSR, 0, 0, 0, 0, REG_UNUSED,                  64'hDEAD_BEEF,           0, 0, 0, 0},
      '{ROW_TICK, 1, 1, 1001,  10000, 0, 0, 0, 0, 0, 0},
      '{ROW_TICK, 0, 0, 0,     10500, 0, 0, 0, 0, 0, 0},
      '{ROW_TICK, 1, 1, 2500,  11001, 0, 0, 0, 0, 0, 0},
      '{ROW_TICK, 1, 1, 2500,  12000, 0, 0, 0, 0, 0, 0},
      '{ROW_TICK, 1, 1, 2500,  13001, 0, 0, 0, 0, 0, 0},
      '{ROW_TICK, 1, 1, 1000,  13002, 0, 0, 0, 0, 0, 0},
      '{ROW_TICK, 1, 1, 0,     14000, 0, 0, 0, 0, 0, 0},
      '{ROW_TICK, 0, 1, 3000,  20000, 0, 0, 0, 0, 0, 0},
      '{ROW_TICK, 1, 1, 2500,  32'hFFFF_FE00, 0, 0, 0, 0, 0, 0},
      '{ROW_TICK, 1, 1, 2500,  32'h0000_0300, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR, 0, 0, 0, 0, co2dta_pkg::REG_CONT_PERIOD, 64'h0,                   0, 0, 0, 0},
      '{ROW_TICK, 0, 0, 0,     32'h0000_0300, 0, 0, 0, 0, 0, 0},
      '{ROW_TICK, 0, 0, 0,     32'h0000_0301, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR, 0, 0, 0, 0, co2dta_pkg::REG_THRESHOLD_1, 64'hFFFF,                0, 0, 0, 0},
      '{ROW_CSR, 0, 0, 0, 0, co2dta_pkg::REG_DELAY_TABLE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0},
      '{ROW_TICK, 1, 1, 65535, 32'h0000_0400, 0, 0, 0, 0, 0, 0}
   };

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("ERROR at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
   endtask

   function automatic logic [1:0] step_limit(input int k, input logic [31:0] now);
      logic [63:0] hold_ms;
      logic [63:0] period_ms;
      logic [31:0] waited;
      logic [1:0]  ev;
      ev = co2dta_pkg::EV_NONE;
      hold_ms = {48'd0, delay_cfg[16*k +: 16]} * 64'd1000;
      period_ms = {48'd0, period_cfg} * 64'd1000;
      if (level_ppm > thr_cfg[k]) begin
         if (hold_ms != 0) begin
            if (!timer_on[k]) begin
               timer_on[k] = 1'b1;
               timer_start[k] = now;
               return co2dta_pkg::EV_NONE;
            end
            waited = now - timer_start[k];
            if ({32'd0, waited} < hold_ms)
               return co2dta_pkg::EV_NONE;
         end
         waited = now - last_report[k];
         if (!crossed_q[k]) begin
            ev = co2dta_pkg::EV_START;
            last_report[k] = now;
         end else if ({32'd0, waited} > period_ms) begin
            ev = co2dta_pkg::EV_CONTINUE;
            last_report[k] = now;
         end
         crossed_q[k] = 1'b1;
      end else begin
         timer_on[k] = 1'b0;
         if (crossed_q[k]) begin
            ev = co2dta_pkg::EV_END;
            crossed_q[k] = 1'b0;
         end
      end
      return ev;
   endfunction

   function automatic alarm_result_type predict_tick(input bit has_sample,
                                                     input bit co2_present,
                                                     input logic [15:0] ppm,
                                                     input logic [31:0] now);
      alarm_result_type r;
      logic [1:0]       ev;
      int unsigned      clamped;
      r = '0;
      if (has_sample) begin
         if (co2_present && ppm != 0) begin
            level_ppm = ppm;
            level_known = 1'b1;
            fault_q = 1'b0;
            buzzer_q = 1'b0;
         end else begin
            fault_q = 1'b1;
            buzzer_q = !buzzer_q;
            level_known = 1'b0;
         end
      end
      if (level_known) begin
         for (int k = 0; k < 4; k++) begin
            ev = step_limit(k, now);
            if (id_mask_cfg[k])
               r.ev[k] = ev;
         end
         clamped = level_ppm > CLAMP_PPM ? CLAMP_PPM : level_ppm;
         r.current_ua = 15'(BASE_UA + (8 * clamped + 1) / 3);
      end
      for (int k = 0; k < 4; k++)
         r.alarm_mask[k] = crossed_q[k];
      r.fault_led = fault_q;
      r.buzzer_on = buzzer_q;
      return r;
   endfunction

   task automatic send_tick(input bit has_sample, input bit co2_present,
                            input logic [15:0] ppm, input logic [31:0] now,
                            input bit literal, input alarm_result_type typed);
      alarm_result_type predicted;
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_has_sample <= has_sample;
      req_co2_present <= co2_present;
      req_co2_ppm <= ppm;
      req_time_ms <= now;
      do @(posedge clock); while (req_stall);
      predicted = predict_tick(has_sample, co2_present, ppm, now);
      pending_results.push_back(literal ? typed : predicted);
      ticks_sent++;
   endtask

   // Settings change only once every outstanding tick has produced its transfer.
   task automatic write_csr(input logic [2:0] idx, input logic [63:0] data);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         co2dta_pkg::REG_THRESHOLD_1: thr_cfg[0] = data[15:0];
         co2dta_pkg::REG_THRESHOLD_2: thr_cfg[1] = data[15:0];
         co2dta_pkg::REG_THRESHOLD_3: thr_cfg[2] = data[15:0];
         co2dta_pkg::REG_THRESHOLD_4: thr_cfg[3] = data[15:0];
         co2dta_pkg::REG_DELAY_TABLE: delay_cfg = data;
         co2dta_pkg::REG_ID_SET_MASK: id_mask_cfg = data[3:0];
         co2dta_pkg::REG_CONT_PERIOD: period_cfg = data[15:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [3:0][15:0] thr, input logic [63:0] dly,
                                 input logic [3:0] idm, input logic [15:0] per);
      logic [63:0]       noisy;
      logic [2:0]        thr_regs [4];
      thr_regs = '{co2dta_pkg::REG_THRESHOLD_1, co2dta_pkg::REG_THRESHOLD_2,
                   co2dta_pkg::REG_THRESHOLD_3, co2dta_pkg::REG_THRESHOLD_4};
      for (int k = 0; k < 4; k++) begin
         noisy = {32'($urandom()), 32'($urandom())};
         noisy[15:0] = thr[k];
         write_csr(thr_regs[k], noisy);
      end
      write_csr(co2dta_pkg::REG_DELAY_TABLE, dly);
      noisy = {32'($urandom()), 32'($urandom())};
      noisy[3:0] = idm;
      write_csr(co2dta_pkg::REG_ID_SET_MASK, noisy);
      noisy = {32'($urandom()), 32'($urandom())};
      noisy[15:0] = per;
      write_csr(co2dta_pkg::REG_CONT_PERIOD, noisy);
   endtask

   always @(posedge clock) begin
      alarm_result_type want;
      logic [3:0][1:0]  got_ev;
      if (!reset && rsp_valid && !rsp_stall) begin
         got_ev = {rsp_event_4, rsp_event_3, rsp_event_2, rsp_event_1};
         if (pending_results.size() == 0) begin
            report_mismatch("result transfer with nothing expected", 1, 0);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            for (int k = 0; k < 4; k++) begin
               if (got_ev[k] != want.ev[k])
                  report_mismatch($sformatf("event_%0d", k + 1), got_ev[k], want.ev[k]);
               if (want.ev[k] == co2dta_pkg::EV_START) starts_seen++;
               if (want.ev[k] == co2dta_pkg::EV_CONTINUE) continues_seen++;
               if (want.ev[k] == co2dta_pkg::EV_END) ends_seen++;
            end
            if (rsp_alarm_mask != want.alarm_mask)
               report_mismatch("alarm_mask", rsp_alarm_mask, want.alarm_mask);
            if (rsp_fault_led != want.fault_led)
               report_mismatch("fault_led", rsp_fault_led, want.fault_led);
            if (rsp_buzzer_on != want.buzzer_on)
               report_mismatch("buzzer_on", rsp_buzzer_on, want.buzzer_on);
            if (rsp_loop_current_ua != want.current_ua)
               report_mismatch("loop_current_ua", rsp_loop_current_ua, want.current_ua);
            if (want.fault_led) faults_seen++;
         end
      end
      if (stall_left > 0)
         stall_left--;
      else if (!no_idle && $urandom_range(0, 4) == 0)
         stall_left = $urandom_range(1, 3);
      rsp_stall <= (stall_left > 0);
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout: outstanding results %0d", pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [3:0][15:0] thr;
      logic [63:0]      dly;
      logic [3:0]       idm;
      logic [15:0]      per;
      logic [31:0]      now_ms;
      logic [15:0]      ppm;
      bit               has_sample, co2_present, calm;
      int               cur_level, v, r, k, wait_cycles;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      no_idle = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_csr(directed_rows[i].idx, directed_rows[i].data);
         else
            send_tick(directed_rows[i].has_sample, directed_rows[i].co2_present,
                      directed_rows[i].ppm, directed_rows[i].time_ms,
                      directed_rows[i].literal,
                      '{ev: '0, alarm_mask: '0, fault_led: directed_rows[i].fault,
                        buzzer_on: directed_rows[i].buzzer,
                        current_ua: directed_rows[i].current});
      end

      now_ms = 32'h0001_0000;
      cur_level = 1000;
      calm = 1'b0;
      for (int phase = 0; phase < PHASES; phase++) begin
         for (k = 0; k < 4; k++) begin
            r = $urandom_range(0, 9);
            thr[k] = r < 7 ? 16'($urandom_range(0, 3000)) : r == 7 ? 16'd0 :
                     r == 8 ? 16'hFFFF : 16'($urandom());
            r = $urandom_range(0, 9);
            dly[16*k +: 16] = r < 4 ? 16'd0 : r < 9 ? 16'($urandom_range(1, 3)) :
                              16'($urandom());
         end
         idm = 4'($urandom_range(0, 15));
         r = $urandom_range(0, 9);
         per = r < 8 ? 16'($urandom_range(1, 4)) : r == 8 ? 16'hFFFF : 16'($urandom());
         if (phase == 0) begin
            thr = '0;
            dly = '0;
            idm = 4'hF;
            per = 16'd1;
         end else if (phase == 1) begin
            for (k = 0; k < 4; k++) thr[k] = 16'($urandom_range(0, 2000));
            dly = '1;
            idm = 4'hF;
            per = 16'hFFFF;
         end else if (phase == 2) begin
            per = 16'd0;
         end
         apply_settings(thr, dly, idm, per);
         calm = (phase == PHASES - 1);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 40 == 0)
               no_idle = calm || ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            has_sample = 1'b1;
            co2_present = 1'b1;
            ppm = 16'($urandom());
            if (r < 10) begin
               has_sample = 1'b0;
               co2_present = 1'($urandom());
            end else if (r < 16) begin
               if ($urandom_range(0, 1) == 0) co2_present = 1'b0;
               else ppm = 16'd0;
            end else begin
               r = $urandom_range(0, 9);
               if (r < 6) begin
                  v = cur_level + $urandom_range(0, 600) - 300;
               end else if (r < 8) begin
                  v = thr_cfg[$urandom_range(0, 3)] + $urandom_range(0, 2) - 1;
               end else if (r == 8) begin
                  v = $urandom_range(1, 8000);
               end else begin
                  v = $urandom_range(0, 65535);
               end
               if (r != 9) v = v < 1 ? 1 : v > 65535 ? 65535 : v;
               ppm = 16'(v);
               if (v > 0) cur_level = v;
            end
            r = $urandom_range(0, 99);
            if (r < 5)       now_ms = now_ms;
            else if (r < 75) now_ms = now_ms + $urandom_range(1, 1500);
            else if (r < 90) now_ms = now_ms + $urandom_range(1500, 6000);
            else if (r < 95) now_ms = now_ms + $urandom_range(0, 70_000_000);
            else             now_ms = $urandom();
            send_tick(has_sample, co2_present, ppm, now_ms, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      for (wait_cycles = 0; wait_cycles < 1000 && pending_results.size() != 0; wait_cycles++)
         @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never delivered", 0, pending_results.size());
      repeat (5) @(posedge clock);
      $display("Run covered %0d ticks under %0d settings, %0d transfers checked.",
               ticks_sent, PHASES + 1, results_checked);
      $display("Expected %0d start, %0d continue and %0d end events, %0d fault ticks.",
               starts_seen, continues_seen, ends_seen, faults_seen);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> co2_delayed_threshold_alarms.f
src/co2dta_pkg.sv
src/co2dta_limit.sv
src/co2_delayed_threshold_alarms.sv
src/co2dta_checker.sv
dv/tb_top.sv
